FILE: rtl/assert_macros.svh
// Assertion helpers used by fragment_reassembly_tracker.
// FRA_ASSERT checks a property on every rising edge of clk_i outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define FRA_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fra_pkg.sv
// ---------------------------------------------------------------------------
// fra_pkg
// Item types, operation and status codes of the reassembly tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package fra_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_FRAG  = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_STORED     = 4'd0,
    ST_COMPLETE   = 4'd1,
    ST_EMPTY      = 4'd2,
    ST_DEGENERATE = 4'd3,
    ST_DUPLICATE  = 4'd4,
    ST_UNKNOWN    = 4'd5,
    ST_FULL       = 4'd6,
    ST_RANGE      = 4'd7,
    ST_FREED      = 4'd8
  } status_e;

  // Smallest total a start may announce
  localparam logic [15:0] MinTotal = 16'd2;

  // Width of the per-entry count and total fields
  localparam int unsigned CntW = 7;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  transfer_id;
    logic [5:0]  fragment_index;
    logic [15:0] total_fragments;
    logic [15:0] payload_bytes;
  } fra_in_t;

  typedef struct packed {
    logic [3:0] status;
    logic       complete;
    logic [6:0] received_count;
    logic [2:0] slot;
  } fra_out_t;

endpackage

`default_nettype wire

FILE: rtl/fra_entry_ram.sv
// ---------------------------------------------------------------------------
// fra_entry_ram
// Entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fra_entry_ram #(
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3,
  parameter int unsigned DataW = 78
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  // Write the entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read the entry, hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: rtl/fra_tag_cam.sv
// ---------------------------------------------------------------------------
// fra_tag_cam
// Valid bits and transfer IDs of all entries, with a parallel ID lookup and
// a lowest-free-entry search.
// ---------------------------------------------------------------------------
`default_nettype none

module fra_tag_cam #(
  parameter int unsigned Entries = 8,
  parameter int unsigned SlotW   = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       lk_id_i,
  output logic             hit_o,
  output logic [SlotW-1:0] hit_slot_o,
  output logic             free_found_o,
  output logic [SlotW-1:0] free_slot_o,
  input  logic             clr_en_i,
  input  logic [SlotW-1:0] clr_slot_i,
  input  logic             set_en_i,
  input  logic [SlotW-1:0] set_slot_i,
  input  logic [7:0]       set_id_i
);

  logic [Entries-1:0] valid_q, valid_d;
  logic [7:0]         tag_q [Entries];
  logic [Entries-1:0] match;
  logic [Entries-1:0] avail;

  // Compare the ID against every entry; a matching entry counts as free
  // because a start drops it before opening
  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      match[i] = valid_q[i] && (tag_q[i] == lk_id_i);
      avail[i] = !valid_q[i] || match[i];
    end
  end

  // Pick the lowest matching and the lowest free entry
  always_comb begin
    hit_o        = |match;
    free_found_o = |avail;
    hit_slot_o   = '0;
    free_slot_o  = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot_o = SlotW'(i);
      end
      if (avail[i]) begin
        free_slot_o = SlotW'(i);
      end
    end
  end

  // Drop first, then open; opening wins when both hit the same entry
  always_comb begin
    valid_d = valid_q;
    if (clr_en_i) begin
      valid_d[clr_slot_i] = 1'b0;
    end
    if (set_en_i) begin
      valid_d[set_slot_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_en_i) begin
      tag_q[set_slot_i] <= set_id_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fragment_reassembly_tracker.sv
// ---------------------------------------------------------------------------
// fragment_reassembly_tracker
// Table of open reassembly transfers: tracks received fragments per ID.
// ---------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i / in_stall_o / in_item_i): start, fragment and
//   free items. out channel (out_valid_o / out_stall_i / out_item_o): one
//   result item per input item, in order.
//   Each item passes an accept state and then an update state: in the accept
//   cycle the ID is matched against the tag array and the entry memory is
//   read; in the update state the entry is updated, written back and the
//   result is loaded into the output register. The single read/modify/write
//   of the entry memory means no new item is taken until the update is done.
//   out_valid_o is registered and rises at the clock edge that ends the
//   update; the result can be taken from then on.
//   The output register lets the next item enter while a result waits.
//   If the receiver stalls with a result still held, the update cycle waits
//   and in_stall_o stays high until the result drains.
//   Reset empties the table (all valid bits clear) and drops any held
//   result; the entry memory needs no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module fragment_reassembly_tracker #(
  parameter int unsigned TABLE_ENTRIES          = 8,
  parameter int unsigned FRAGMENTS_PER_TRANSFER = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fra_pkg::fra_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fra_pkg::fra_out_t out_item_o
);

  import fra_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned SlotW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned MapW  = FRAGMENTS_PER_TRANSFER;
  localparam int unsigned IdxW  = $clog2(FRAGMENTS_PER_TRANSFER);
  localparam int unsigned EntW  = MapW + 2 * CntW;

  localparam logic [6:0]  FragLimit  = 7'(FRAGMENTS_PER_TRANSFER);
  localparam logic [15:0] TotalLimit = 16'(FRAGMENTS_PER_TRANSFER);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic in_fire, exec_fire;

  fra_in_t            req_q;
  logic               hit_q;
  logic [SlotW-1:0]   hit_slot_q;
  logic               free_found_q;
  logic [SlotW-1:0]   free_slot_q;

  logic               lk_hit, lk_free_found;
  logic [SlotW-1:0]   lk_hit_slot, lk_free_slot;

  logic               clr_en, set_en;
  logic [SlotW-1:0]   clr_slot;

  logic [EntW-1:0]    rd_data;
  logic [CntW-1:0]    ent_total, ent_count, new_count;
  logic [MapW-1:0]    ent_map;
  logic [IdxW-1:0]    idx_sel;
  logic               wr_en;
  logic [SlotW-1:0]   wr_slot;
  logic [EntW-1:0]    wr_data;

  fra_out_t           res;
  logic [SlotW+2:0]   slot_ext;
  logic [SlotW-1:0]   res_slot;

  logic               out_valid_q, out_valid_d;
  fra_out_t           out_item_q;

  // Handshakes
  assign in_stall_o = (state_q == StExec);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign exec_fire  = (state_q == StExec) && (!out_valid_q || !out_stall_i);

  fra_tag_cam #(
    .Entries (TABLE_ENTRIES),
    .SlotW   (SlotW)
  ) u_cam (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lk_id_i      (in_item_i.transfer_id),
    .hit_o        (lk_hit),
    .hit_slot_o   (lk_hit_slot),
    .free_found_o (lk_free_found),
    .free_slot_o  (lk_free_slot),
    .clr_en_i     (clr_en),
    .clr_slot_i   (clr_slot),
    .set_en_i     (set_en),
    .set_slot_i   (free_slot_q),
    .set_id_i     (req_q.transfer_id)
  );

  fra_entry_ram #(
    .Depth (TABLE_ENTRIES),
    .AddrW (SlotW),
    .DataW (EntW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (lk_hit_slot),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_slot),
    .wr_data_i (wr_data)
  );

  // Hold the item and its lookup result for the update cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q        <= in_item_i;
      hit_q        <= lk_hit;
      hit_slot_q   <= lk_hit_slot;
      free_found_q <= lk_free_found;
      free_slot_q  <= lk_free_slot;
    end
  end

  // Split the entry read back from memory
  assign ent_total = rd_data[EntW-1 -: CntW];
  assign ent_map   = rd_data[CntW +: MapW];
  assign ent_count = rd_data[CntW-1:0];
  assign idx_sel   = req_q.fragment_index[IdxW-1:0];
  assign new_count = (ent_count != 7'h7f) ? ent_count + 7'd1 : ent_count;

  // Decide the result and the table update
  always_comb begin
    res      = '0;
    res.status = ST_RANGE;
    res_slot = '0;
    clr_en   = 1'b0;
    clr_slot = hit_slot_q;
    set_en   = 1'b0;
    wr_en    = 1'b0;
    wr_slot  = hit_slot_q;
    wr_data  = rd_data;
    case (req_q.operation)
      OP_START: begin
        if (req_q.payload_bytes == 16'd0) begin
          res.status = ST_EMPTY;
        end else if (req_q.total_fragments < MinTotal) begin
          res.status = ST_DEGENERATE;
        end else if (req_q.total_fragments > TotalLimit) begin
          res.status = ST_RANGE;
        end else begin
          clr_en = hit_q && exec_fire;
          if (!free_found_q) begin
            res.status = ST_FULL;
          end else begin
            set_en   = exec_fire;
            wr_en    = exec_fire;
            wr_slot  = free_slot_q;
            wr_data  = {req_q.total_fragments[CntW-1:0], MapW'(1), 7'd1};
            res.complete       = (7'd1 >= req_q.total_fragments[CntW-1:0]);
            res.status         = res.complete ? ST_COMPLETE : ST_STORED;
            res.received_count = 7'd1;
            res_slot           = free_slot_q;
          end
        end
      end
      OP_FRAG: begin
        if (req_q.payload_bytes == 16'd0) begin
          res.status = ST_EMPTY;
        end else if ({1'b0, req_q.fragment_index} >= FragLimit) begin
          res.status = ST_RANGE;
        end else if (!hit_q) begin
          res.status = ST_UNKNOWN;
        end else if (ent_map[idx_sel]) begin
          res.status         = ST_DUPLICATE;
          res.complete       = (ent_count >= ent_total);
          res.received_count = ent_count;
          res_slot           = hit_slot_q;
        end else begin
          wr_en   = exec_fire;
          wr_data = {ent_total, ent_map | (MapW'(1) << idx_sel), new_count};
          res.complete       = (new_count >= ent_total);
          res.status         = res.complete ? ST_COMPLETE : ST_STORED;
          res.received_count = new_count;
          res_slot           = hit_slot_q;
        end
      end
      OP_FREE: begin
        if (!hit_q) begin
          res.status = ST_UNKNOWN;
        end else begin
          clr_en             = exec_fire;
          res.status         = ST_FREED;
          res.complete       = (ent_count >= ent_total);
          res.received_count = ent_count;
          res_slot           = hit_slot_q;
        end
      end
      default: begin
        res.status = ST_RANGE;
      end
    endcase
    slot_ext = {3'b000, res_slot};
    res.slot = slot_ext[2:0];
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_fire) state_d = StExec;
      StExec: if (exec_fire) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register: load on update, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks
  `FRA_ASSERT(a_accept_enters_exec, in_fire |=> (state_q == StExec), "accepted item did not enter update")
  `FRA_ASSERT(a_result_after_exec, $rose(out_valid_o) |-> $past(state_q == StExec), "result without update cycle")
  `FRA_ASSERT(a_complete_flag, (out_valid_o && (out_item_o.status == ST_COMPLETE)) |-> out_item_o.complete, "complete status without complete flag")

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for fragment_reassembly_tracker.
// A queue of start, fragment and free items feeds a clocked driver; a
// clocked monitor compares each result item against a table model updated
// at every accepted input. Directed corner items come first, then random
// transfers with noise, under three phases of sender idling and receiver
// stalls.
// ---------------------------------------------------------------------------

module tb;

  import fra_pkg::*;

  localparam int unsigned NumEntries   = 8;
  localparam int unsigned FragsPerXfer = 64;
  localparam int          RandomItems  = 1900;
  localparam int          LimitCycles  = 200000;
  localparam int          DrainCycles  = 8;

  // Operation code outside the defined set
  localparam logic [1:0] OpUndefined = 2'd3;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  fra_in_t  in_item   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  fra_out_t out_item;

  fra_in_t  pending_items[$];
  fra_out_t expected_results[$];
  int       total_items;
  int       items_accepted = 0;
  int       results_seen   = 0;
  int       mismatch_cnt   = 0;
  int       cycle_cnt      = 0;
  int       status_seen[16];
  int       send_idle_pct  = 15;
  int       recv_stall_pct = 61;

  // Table model
  logic        tab_valid[NumEntries];
  logic [7:0]  tab_id[NumEntries];
  logic [6:0]  tab_total[NumEntries];
  logic [63:0] tab_map[NumEntries];
  logic [6:0]  tab_count[NumEntries];

  fragment_reassembly_tracker #(
    .TABLE_ENTRIES         (NumEntries),
    .FRAGMENTS_PER_TRANSFER(FragsPerXfer)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #10 clk_i = ~clk_i;

  // Build a result item from an entry, or an empty one when no entry applies
  function automatic fra_out_t entry_result(status_e st, int s);
    fra_out_t r;
    r = '0;
    r.status = st;
    if (s >= 0) begin
      r.complete       = (tab_count[s] >= tab_total[s]);
      r.received_count = tab_count[s];
      r.slot           = 3'(s);
    end
    return r;
  endfunction

  // Lowest valid entry holding the ID, -1 if none
  function automatic int lookup_id(logic [7:0] id);
    int k;
    for (k = 0; k < NumEntries; k++) begin
      if (tab_valid[k] && tab_id[k] == id) return k;
    end
    return -1;
  endfunction

  // Apply one item to the table model and return its result
  function automatic fra_out_t track_item(fra_in_t it);
    int          s;
    int          k;
    logic [63:0] frag_bit;
    fra_out_t    r;
    s = -1;
    case (it.operation)
      OP_START: begin
        if (it.payload_bytes == 16'd0) begin
          r = entry_result(ST_EMPTY, -1);
        end else if (it.total_fragments < MinTotal) begin
          r = entry_result(ST_DEGENERATE, -1);
        end else if (it.total_fragments > 16'(FragsPerXfer)) begin
          r = entry_result(ST_RANGE, -1);
        end else begin
          // drop stale entries of this ID, then open the lowest free one
          for (k = 0; k < NumEntries; k++) begin
            if (tab_valid[k] && tab_id[k] == it.transfer_id) tab_valid[k] = 1'b0;
          end
          for (k = NumEntries - 1; k >= 0; k--) begin
            if (!tab_valid[k]) s = k;
          end
          if (s < 0) begin
            r = entry_result(ST_FULL, -1);
          end else begin
            tab_valid[s] = 1'b1;
            tab_id[s]    = it.transfer_id;
            tab_total[s] = it.total_fragments[6:0];
            tab_map[s]   = 64'd1;
            tab_count[s] = 7'd1;
            r = entry_result((tab_count[s] >= tab_total[s]) ? ST_COMPLETE : ST_STORED, s);
          end
        end
      end
      OP_FRAG: begin
        if (it.payload_bytes == 16'd0) begin
          r = entry_result(ST_EMPTY, -1);
        end else if (int'(it.fragment_index) >= FragsPerXfer) begin
          r = entry_result(ST_RANGE, -1);
        end else begin
          s = lookup_id(it.transfer_id);
          frag_bit = 64'd1 << it.fragment_index;
          if (s < 0) begin
            r = entry_result(ST_UNKNOWN, -1);
          end else if ((tab_map[s] & frag_bit) != 64'd0) begin
            r = entry_result(ST_DUPLICATE, s);
          end else begin
            tab_map[s] = tab_map[s] | frag_bit;
            if (tab_count[s] != 7'd127) tab_count[s] = tab_count[s] + 7'd1;
            r = entry_result((tab_count[s] >= tab_total[s]) ? ST_COMPLETE : ST_STORED, s);
          end
        end
      end
      OP_FREE: begin
        s = lookup_id(it.transfer_id);
        if (s < 0) begin
          r = entry_result(ST_UNKNOWN, -1);
        end else begin
          r = entry_result(ST_FREED, s);
          tab_valid[s] = 1'b0;
        end
      end
      default: begin
        r = entry_result(ST_RANGE, -1);
      end
    endcase
    return r;
  endfunction

  task automatic push_item(logic [1:0] op, logic [7:0] id, logic [5:0] idx,
                           logic [15:0] tot, logic [15:0] nbytes);
    fra_in_t it;
    it.operation       = op;
    it.transfer_id     = id;
    it.fragment_index  = idx;
    it.total_fragments = tot;
    it.payload_bytes   = nbytes;
    pending_items.insert(pending_items.size(), it);
  endtask

  // Mostly a small ID pool so IDs collide and get reused
  function automatic logic [7:0] pick_id();
    if ($urandom_range(99, 0) < 80) return 8'($urandom_range(15, 0));
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic logic [15:0] pick_bytes();
    if ($urandom_range(99, 0) < 3) return 16'd0;
    return 16'($urandom_range(65535, 1));
  endfunction

  // One well-formed transfer with random order, duplicates and gaps
  task automatic gen_transfer();
    logic [7:0] id;
    int         tot;
    int         k;
    int         j;
    int         tmp;
    int         order[$];
    id  = pick_id();
    tot = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 2) : $urandom_range(10, 2);
    push_item(OP_START, id, 6'($urandom_range(63, 0)), 16'(tot), pick_bytes());
    for (k = 1; k < tot; k++) order.insert(order.size(), k);
    for (k = order.size() - 1; k > 0; k--) begin
      j = $urandom_range(k, 0);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) begin
      if ($urandom_range(99, 0) < 5) continue;
      push_item(OP_FRAG, id, 6'(order[k]), 16'($urandom), pick_bytes());
      if ($urandom_range(99, 0) < 5) begin
        push_item(OP_FRAG, id, 6'(order[$urandom_range(k, 0)]), 16'($urandom), pick_bytes());
      end
      if ($urandom_range(99, 0) < 4) begin
        push_item(OP_FRAG, id, 6'($urandom_range(63, 0)), 16'($urandom), pick_bytes());
      end
    end
    if ($urandom_range(9, 0) != 0) begin
      push_item(OP_FREE, id, 6'($urandom_range(63, 0)), 16'($urandom), pick_bytes());
    end
  endtask

  // Random item of any operation, including the undefined one
  task automatic gen_noise();
    logic [15:0] tot;
    tot = ($urandom_range(1, 0) == 0) ? 16'($urandom_range(65535, 0))
                                      : 16'($urandom_range(70, 0));
    push_item(2'($urandom_range(3, 0)), pick_id(), 6'($urandom_range(63, 0)), tot,
              pick_bytes());
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // Stimulus, reset and end of run
  initial begin
    foreach (tab_valid[k]) tab_valid[k] = 1'b0;
    foreach (status_seen[k]) status_seen[k] = 0;

    // start rejects: empty, degenerate totals, totals over range
    push_item(OP_START, 8'd5, 6'd0, 16'd4, 16'd0);
    push_item(OP_START, 8'd5, 6'd0, 16'd0, 16'd10);
    push_item(OP_START, 8'd5, 6'd0, 16'd1, 16'd10);
    push_item(OP_START, 8'd5, 6'd0, 16'd65, 16'd10);
    push_item(OP_START, 8'd5, 6'd63, 16'hffff, 16'hffff);
    // largest legal transfer and a two-fragment one
    push_item(OP_START, 8'd255, 6'd0, 16'd64, 16'hffff);
    push_item(OP_START, 8'd0, 6'd0, 16'd2, 16'd1);
    // complete, keep recording after completion, duplicate, empty, unknown
    push_item(OP_FRAG, 8'd0, 6'd1, 16'd0, 16'd100);
    push_item(OP_FRAG, 8'd0, 6'd63, 16'd0, 16'hffff);
    push_item(OP_FRAG, 8'd0, 6'd0, 16'd0, 16'd100);
    push_item(OP_FRAG, 8'd0, 6'd2, 16'd0, 16'd0);
    push_item(OP_FRAG, 8'd77, 6'd1, 16'd0, 16'd100);
    // restart a known ID, undefined operation, free of an unknown ID
    push_item(OP_START, 8'd0, 6'd0, 16'd3, 16'd8);
    push_item(OpUndefined, 8'd0, 6'd0, 16'd0, 16'd8);
    push_item(OP_FREE, 8'd77, 6'd0, 16'd0, 16'd0);
    // fill the table, hit a full table, restart a known ID while full
    for (int k = 1; k <= 6; k++) push_item(OP_START, 8'(k), 6'd0, 16'd5, 16'd20);
    push_item(OP_START, 8'd7, 6'd0, 16'd5, 16'd20);
    push_item(OP_START, 8'd255, 6'd0, 16'd2, 16'd20);
    push_item(OP_FREE, 8'd255, 6'd0, 16'd0, 16'd0);

    total_items = pending_items.size() + RandomItems;
    while (pending_items.size() < total_items) begin
      if ($urandom_range(99, 0) < 80) gen_transfer();
      else gen_noise();
    end
    total_items = pending_items.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every item to go in and every result to come back
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d items in, %0d results checked", items_accepted, results_seen);
    $display("completions %0d, duplicates %0d, table full %0d, frees %0d, unknown %0d",
             status_seen[ST_COMPLETE], status_seen[ST_DUPLICATE], status_seen[ST_FULL],
             status_seen[ST_FREED], status_seen[ST_UNKNOWN]);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Pick idle rates by run phase
  always @(posedge clk_i) begin
    if (items_accepted < total_items / 3) begin
      send_idle_pct  <= 15;
      recv_stall_pct <= 61;
    end else if (items_accepted < (2 * total_items) / 3) begin
      send_idle_pct  <= 61;
      recv_stall_pct <= 15;
    end else begin
      send_idle_pct  <= 0;
      recv_stall_pct <= 0;
    end
  end

  // Driver: predict on accept, then present the next item or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(), track_item(in_item));
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    fra_out_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        status_seen[out_item.status]++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got status %0d count %0d slot %0d",
                   $time, out_item.status, out_item.received_count, out_item.slot);
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_item.status);
          check_field("complete", want.complete, out_item.complete);
          check_field("received_count", want.received_count, out_item.received_count);
          check_field("slot", want.slot, out_item.slot);
        end
      end
      out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
